// ===== src/scp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, opcodes, status codes and item types of the stack
// calculator core.
// ----------------------------------------------------------------------------
package scp_pkg;

    // stack geometry and data word
    localparam int STACK_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    // item field widths
    localparam int CMD_W    = 3;
    localparam int PUSH_W   = 32;
    localparam int TOP_W    = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // opcodes
    localparam logic [CMD_W-1:0] OP_NOP  = 3'd0;
    localparam logic [CMD_W-1:0] OP_PUSH = 3'd1;
    localparam logic [CMD_W-1:0] OP_ADD  = 3'd2;
    localparam logic [CMD_W-1:0] OP_SUB  = 3'd3;
    localparam logic [CMD_W-1:0] OP_MUL  = 3'd4;
    localparam logic [CMD_W-1:0] OP_DIV  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

    typedef logic [DATA_WIDTH-1:0] t_data;

    // instruction class seen by the back end
    typedef enum logic [1:0] {
        K_NOP,
        K_PUSH,
        K_ARITH
    } t_kind;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [PUSH_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [TOP_W-1:0] top_value;
        logic [COUNT_W-1:0]      stack_count;
        logic [STATUS_W-1:0]     status;
    } t_out_item;

    // decoded instruction carried through the queue
    typedef struct packed {
        t_kind            kind;
        logic [CMD_W-1:0] cmd;
        t_data            value;
    } t_op;

endpackage
`default_nettype wire

// ===== src/scp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scp_front
// Accepts instruction items, classifies them and writes them to the queue.
// ----------------------------------------------------------------------------
module scp_front (
    input  wire                logic i_in_valid,
    output logic                     o_in_ready,
    input  wire scp_pkg::t_in_item   i_in_item,
    input  wire                logic i_q_full,
    output logic                     o_push,
    output scp_pkg::t_op             o_push_op
);
    import scp_pkg::*;

    // accept whenever the queue has room
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // classify the opcode, unused codes behave as nop
    always_comb begin
        o_push_op.cmd   = i_in_item.cmd;
        o_push_op.value = DATA_WIDTH'(i_in_item.push_value);
        if (i_in_item.cmd == OP_PUSH) begin
            o_push_op.kind = K_PUSH;
        end else if (i_in_item.cmd inside {[OP_ADD:OP_DIV]}) begin
            o_push_op.kind = K_ARITH;
        end else begin
            o_push_op.kind = K_NOP;
        end
    end

endmodule
`default_nettype wire

// ===== src/scp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scp_queue
// Short first-in first-out queue of decoded instructions between the front
// and the back end.
// ----------------------------------------------------------------------------
module scp_queue (
    input  wire          logic i_clk,
    input  wire          logic i_rst_n,
    input  wire          logic i_push,
    input  wire scp_pkg::t_op  i_push_op,
    output logic               o_full,
    output logic               o_valid,
    output scp_pkg::t_op       o_head,
    input  wire          logic i_pop
);
    import scp_pkg::*;

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_op             r_slot [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wptr, n_wptr;
    logic [QA_W-1:0] r_rptr, n_rptr;
    logic [QC_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QC_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_push_op;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== src/scp_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scp_divider
// Iterative signed divider, one quotient bit per cycle, truncating toward
// zero with the quotient wrapping at the data width.
// ----------------------------------------------------------------------------
module scp_divider (
    input  wire            logic i_clk,
    input  wire            logic i_rst_n,
    input  wire            logic i_start,
    input  wire scp_pkg::t_data  i_dividend,
    input  wire scp_pkg::t_data  i_divisor,
    output logic                 o_done,
    output scp_pkg::t_data       o_quotient
);
    import scp_pkg::*;

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    t_data                 r_rem;
    t_data                 r_quo;
    t_data                 r_div;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    t_data                 a_mag;
    t_data                 b_mag;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   diff;

    // operand magnitudes
    assign a_mag = i_dividend[DATA_WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign b_mag = i_divisor[DATA_WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;

    // one restoring step
    assign rem_sh = {r_rem, r_quo[DATA_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_div};

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= a_mag;
            r_div <= b_mag;
            r_neg <= i_dividend[DATA_WIDTH-1] ^ i_divisor[DATA_WIDTH-1];
        end else if (r_busy) begin
            if (!diff[DATA_WIDTH]) begin
                r_rem <= diff[DATA_WIDTH-1:0];
            end else begin
                r_rem <= rem_sh[DATA_WIDTH-1:0];
            end
            r_quo <= {r_quo[DATA_WIDTH-2:0], !diff[DATA_WIDTH]};
        end
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/scp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scp_back
// Executes decoded instructions on the stack memory and delivers one result
// item per instruction through an output register.
// ----------------------------------------------------------------------------
module scp_back (
    input  wire            logic i_clk,
    input  wire            logic i_rst_n,
    input  wire            logic i_q_valid,
    input  wire scp_pkg::t_op    i_q_head,
    output logic                 o_pop,
    output logic                 o_div_start,
    output scp_pkg::t_data       o_div_dividend,
    output scp_pkg::t_data       o_div_divisor,
    input  wire            logic i_div_done,
    input  wire scp_pkg::t_data  i_div_quotient,
    output logic                 o_out_valid,
    input  wire            logic i_out_ready,
    output scp_pkg::t_out_item   o_out_item
);
    import scp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_FIN
    } t_state;

    t_state            r_state, n_state;
    logic [SP_W-1:0]   r_sp, n_sp;
    t_data             r_top, n_top;
    t_op               r_cur, n_cur;
    t_data             r_res, n_res;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_data             r_stack [STACK_DEPTH];
    t_data             r_rd_data;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_data             w_wdata;
    logic              w_re;
    logic [SP_W-1:0]   sp_m2;
    logic              slot_free;
    logic              arith_go;
    logic [STATUS_W-1:0] st;

    // result item from the state after the step
    function automatic t_out_item make_out(logic [SP_W-1:0] sp, t_data top,
                                           logic [STATUS_W-1:0] status);
        t_out_item o;
        o.top_value   = (sp == '0) ? '0 : TOP_W'(top);
        o.stack_count = COUNT_W'(sp);
        o.status      = status;
        return o;
    endfunction

    assign sp_m2     = r_sp - SP_W'(2);
    assign slot_free = !r_out_valid || i_out_ready;
    assign arith_go  = (i_q_head.kind == K_ARITH) && (r_sp >= SP_W'(2))
                       && !((i_q_head.cmd == OP_DIV) && (r_top == '0));

    assign o_div_dividend = r_rd_data;
    assign o_div_divisor  = r_top;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_top       = r_top;
        n_cur       = r_cur;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = sp_m2[ADDR_W-1:0];
        w_wdata     = r_res;
        w_re        = 1'b0;
        o_pop       = 1'b0;
        o_div_start = 1'b0;
        st          = ST_OK;

        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_q_valid && arith_go) begin
                    // operands present: fetch the left one
                    o_pop   = 1'b1;
                    w_re    = 1'b1;
                    n_cur   = i_q_head;
                    n_state = S_READ;
                end else if (i_q_valid && slot_free) begin
                    o_pop = 1'b1;
                    case (i_q_head.kind)
                        K_PUSH: begin
                            if (r_sp >= SP_W'(STACK_DEPTH)) begin
                                st = ST_OVER;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_sp[ADDR_W-1:0];
                                w_wdata = i_q_head.value;
                                n_top   = i_q_head.value;
                                n_sp    = r_sp + 1'b1;
                            end
                        end
                        K_ARITH: begin
                            st = (r_sp < SP_W'(2)) ? ST_UNDER : ST_DIVZ;
                        end
                        default: begin
                            st = ST_OK;
                        end
                    endcase
                    n_out       = make_out(n_sp, n_top, st);
                    n_out_valid = 1'b1;
                end
            end
            S_READ: begin
                if (r_cur.cmd == OP_DIV) begin
                    o_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    case (r_cur.cmd)
                        OP_ADD:  n_res = r_rd_data + r_top;
                        OP_SUB:  n_res = r_rd_data - r_top;
                        default: n_res = DATA_WIDTH'(r_rd_data * r_top);
                    endcase
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_res   = i_div_quotient;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // pop two, push the result
                if (slot_free) begin
                    w_we        = 1'b1;
                    n_top       = r_res;
                    n_sp        = r_sp - 1'b1;
                    n_out       = make_out(n_sp, r_res, ST_OK);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // stack memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_stack[sp_m2[ADDR_W-1:0]];
        end
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_cur <= n_cur;
        r_res <= n_res;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== src/stack_calculator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stack_calculator_core
// Stack machine calculator: nop, push, add, sub, mul and div on a bounded
// stack, one result item per instruction item.
// ----------------------------------------------------------------------------
// sequence: nop/push results are registered on leaving the queue, add/sub/mul
//   go via S_READ and S_FIN, div via S_READ, S_DIV (one quotient bit per cycle
//   in the iterative divider) and S_FIN; the back-end sequencer takes one nop/push per cycle
//   while the output is not stalled, one operation at a time; a two-entry queue decouples input
// reset: synchronous active low, empties the stack and the queue; stack
//   memory contents are left as they are
module stack_calculator_core (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output logic                     o_in_ready,
    input  wire scp_pkg::t_in_item   i_in_item,
    output logic                     o_out_valid,
    input  wire                logic i_out_ready,
    output scp_pkg::t_out_item       o_out_item
);
    import scp_pkg::*;

    logic  q_push;
    t_op   q_push_op;
    logic  q_full;
    logic  q_valid;
    t_op   q_head;
    logic  q_pop;
    logic  div_start;
    t_data div_dividend;
    t_data div_divisor;
    logic  div_done;
    t_data div_quotient;

    // decode
    scp_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_op  (q_push_op)
    );

    // instruction queue
    scp_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (q_push_op),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_head    (q_head),
        .i_pop     (q_pop)
    );

    // divide unit
    scp_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // execute
    scp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_head       (q_head),
        .o_pop          (q_pop),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_item)
    );

endmodule
`default_nettype wire

// ===== src/scp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks of the stack calculator core, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    input  wire                logic o_in_ready,
    input  wire scp_pkg::t_in_item   i_in_item,
    input  wire                logic o_out_valid,
    input  wire                logic i_out_ready,
    input  wire scp_pkg::t_out_item  o_out_item
);
    import scp_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // depth never exceeds the stack size
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.stack_count <= COUNT_W'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    // overflow only on a full stack
    a_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_OVER)
        |-> o_out_item.stack_count == COUNT_W'(STACK_DEPTH))
        else $error("overflow reported on a stack that is not full");

    // underflow only with fewer than two entries
    a_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_UNDER)
        |-> o_out_item.stack_count < COUNT_W'(2))
        else $error("underflow reported with two or more entries");

    // empty stack reads as zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.stack_count == '0)
        |-> o_out_item.top_value == '0)
        else $error("nonzero top on an empty stack");

endmodule

bind stack_calculator_core scp_checker u_scp_checker (.*);
`default_nettype wire
